// ===== sv/confusion_matrix_accumulator_core_assert.svh =====
// assertion macros shared by the confusion matrix accumulator rtl
`ifndef CONFUSION_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH
`define CONFUSION_MATRIX_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMA_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CMA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== sv/cma_pkg.sv =====
// types and constants of the confusion matrix accumulator
package cma_pkg;

   localparam int MAX_CLASSES_DEFAULT = 16;

   localparam int CLASS_W  = 4;
   localparam int CCOUNT_W = 5;
   localparam int AMOUNT_W = 16;
   localparam int CELL_W   = 32;
   localparam int TOTAL_W  = 40;
   localparam int PCT_W    = 15;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   // accuracy scale: 100 percent in units of 1/256 percent, 25600 = 25 * 1024
   localparam int PCT_SCALE   = 25600;
   localparam int SCALE_SHIFT = 10;
   localparam int SCALED_W    = TOTAL_W + 5;

   // word index of the class_count register
   localparam logic REG_CLASS_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

endpackage

// ===== sv/confusion_matrix_accumulator_core.sv =====
// confusion matrix accumulator with overall accuracy query
//
//   channel   direction   handshake           payload
//   req       in          req_valid/ready     action, expected/actual class, add amount
//   rsp       out         rsp_valid/ready     accepted, cell count, accuracy valid/pct
//   csr       in/out      apb psel/penable    class_count at byte address 0
//
// add and read first read the cell memory; an add then modifies the cell and writes it back.
// a query runs a shift-add scale then a radix-2 restoring divider of 15 quotient bits,
// then posts the result; with a zero grand total it skips the divider.
// reset runs a clearing pass over all MAX_CLASSES*MAX_CLASSES cells of the cell memory;
// no request is taken meanwhile, csr writes are.
// one item is in flight at a time; a result waiting in the output register stalls
// only the item that follows it.
`include "confusion_matrix_accumulator_core_assert.svh"

module confusion_matrix_accumulator_core
   import cma_pkg::*;
#(
   parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [CLASS_W-1:0]  req_expected_class,
   input  logic [CLASS_W-1:0]  req_actual_class,
   input  logic [AMOUNT_W-1:0] req_add_amount,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_accepted,
   output logic [CELL_W-1:0]   rsp_cell_count,
   output logic                rsp_accuracy_valid,
   output logic [PCT_W-1:0]    rsp_accuracy_pct,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   localparam int DEPTH  = MAX_CLASSES * MAX_CLASSES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int STEP_W = $clog2(PCT_W);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } state_type;

   // registers
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [CCOUNT_W-1:0]   class_count_ff, class_count_in;
   logic [TOTAL_W-1:0]    diagonal_total_ff, diagonal_total_in;
   logic [TOTAL_W-1:0]    grand_total_ff, grand_total_in;
   action_type            act_ff, act_in;
   logic                  in_range_ff, in_range_in;
   logic                  on_diag_ff, on_diag_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [AMOUNT_W-1:0]   amount_ff, amount_in;
   logic [TOTAL_W-1:0]    rem_ff, rem_in;
   logic [PCT_W-1:0]      num_ff, num_in;
   logic [PCT_W-1:0]      quot_ff, quot_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [CELL_W-1:0]     rsp_cell_count_ff, rsp_cell_count_in;
   logic                  rsp_accuracy_valid_ff, rsp_accuracy_valid_in;
   logic [PCT_W-1:0]      rsp_accuracy_pct_ff, rsp_accuracy_pct_in;

   // cell memory
   logic [CELL_W-1:0]     cells [DEPTH];
   logic [CELL_W-1:0]     rd_data_ff;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [CELL_W-1:0]     mem_wdata;

   logic                  req_xfer;
   logic                  csr_write;
   logic                  out_free;
   logic                  row_ok;
   logic                  col_ok;
   logic [CELL_W-1:0]     grow;
   logic [CELL_W-1:0]     new_cell;
   logic [TOTAL_W:0]      grand_sum;
   logic [TOTAL_W:0]      diag_sum;
   logic [SCALED_W-1:0]   diag_scaled;
   logic [TOTAL_W:0]      trial;
   logic [TOTAL_W:0]      trial_diff;
   logic [PCT_W-1:0]      pct_clamped;

   assign req_xfer  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // index range check against class_count and the table size
   assign row_ok = ({1'b0, req_expected_class} < class_count_ff)
                   && (int'(req_expected_class) < MAX_CLASSES);
   assign col_ok = ({1'b0, req_actual_class} < class_count_ff)
                   && (int'(req_actual_class) < MAX_CLASSES);

   // saturating cell growth and running totals
   assign grow      = (CELL_W'(amount_ff) < ~rd_data_ff) ? CELL_W'(amount_ff) : ~rd_data_ff;
   assign new_cell  = rd_data_ff + grow;
   assign grand_sum = {1'b0, grand_total_ff} + (TOTAL_W + 1)'(grow);
   assign diag_sum  = {1'b0, diagonal_total_ff} + (TOTAL_W + 1)'(grow);

   // diagonal times 25; the remaining factor 1024 is a shift
   assign diag_scaled = (SCALED_W'(diagonal_total_ff) << 4)
                        + (SCALED_W'(diagonal_total_ff) << 3)
                        + SCALED_W'(diagonal_total_ff);

   // one restoring divider step
   assign trial      = {rem_ff, num_ff[PCT_W-1]};
   assign trial_diff = trial - {1'b0, grand_total_ff};

   assign pct_clamped = (int'(quot_ff) > PCT_SCALE) ? PCT_W'(PCT_SCALE) : quot_ff;

   // memory port control
   assign mem_re    = req_xfer;
   assign mem_raddr = ADDR_W'(int'(req_expected_class) * MAX_CLASSES
                              + int'(req_actual_class));

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = new_cell;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_EXEC && act_ff == ACT_ADD && in_range_ff && out_free) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cells[mem_raddr];
      end
   end

   // next state and registered outputs
   always_comb begin
      state_in              = state_ff;
      clr_in                = clr_ff;
      class_count_in        = class_count_ff;
      diagonal_total_in     = diagonal_total_ff;
      grand_total_in        = grand_total_ff;
      act_in                = act_ff;
      in_range_in           = in_range_ff;
      on_diag_in            = on_diag_ff;
      addr_in               = addr_ff;
      amount_in             = amount_ff;
      rem_in                = rem_ff;
      num_in                = num_ff;
      quot_in               = quot_ff;
      step_in               = step_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_accepted_in       = rsp_accepted_ff;
      rsp_cell_count_in     = rsp_cell_count_ff;
      rsp_accuracy_valid_in = rsp_accuracy_valid_ff;
      rsp_accuracy_pct_in   = rsp_accuracy_pct_ff;

      // csr write
      if (csr_write && paddr[2] == REG_CLASS_COUNT) begin
         class_count_in = pwdata[CCOUNT_W-1:0];
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               act_in      = action_type'(req_action);
               in_range_in = row_ok && col_ok;
               on_diag_in  = (req_expected_class == req_actual_class);
               addr_in     = mem_raddr;
               amount_in   = req_add_amount;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACT_QUERY && grand_total_ff != '0) begin
               // load the divider: upper dividend bits as remainder
               rem_in   = diag_scaled[SCALED_W-1:SCALED_W-TOTAL_W];
               num_in   = {diag_scaled[SCALED_W-TOTAL_W-1:0], SCALE_SHIFT'(0)};
               quot_in  = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_accepted_in       = 1'b0;
               rsp_cell_count_in     = '0;
               rsp_accuracy_valid_in = 1'b0;
               rsp_accuracy_pct_in   = '0;
               state_in              = ST_IDLE;
               if ((act_ff == ACT_ADD || act_ff == ACT_READ) && in_range_ff) begin
                  rsp_accepted_in   = 1'b1;
                  rsp_cell_count_in = (act_ff == ACT_ADD) ? new_cell : rd_data_ff;
               end
               if (act_ff == ACT_ADD && in_range_ff) begin
                  grand_total_in = grand_sum[TOTAL_W] ? '1 : grand_sum[TOTAL_W-1:0];
                  if (on_diag_ff) begin
                     diagonal_total_in = diag_sum[TOTAL_W] ? '1 : diag_sum[TOTAL_W-1:0];
                  end
               end
            end
         end
         ST_DIV: begin
            num_in  = num_ff << 1;
            step_in = step_ff + 1'b1;
            if (!trial_diff[TOTAL_W]) begin
               rem_in  = trial_diff[TOTAL_W-1:0];
               quot_in = {quot_ff[PCT_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[TOTAL_W-1:0];
               quot_in = {quot_ff[PCT_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(PCT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_accepted_in       = 1'b0;
               rsp_cell_count_in     = '0;
               rsp_accuracy_valid_in = 1'b1;
               rsp_accuracy_pct_in   = pct_clamped;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         clr_ff            <= '0;
         class_count_ff    <= '0;
         diagonal_total_ff <= '0;
         grand_total_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_ff            <= clr_in;
         class_count_ff    <= class_count_in;
         diagonal_total_ff <= diagonal_total_in;
         grand_total_ff    <= grand_total_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      act_ff                <= act_in;
      in_range_ff           <= in_range_in;
      on_diag_ff            <= on_diag_in;
      addr_ff               <= addr_in;
      amount_ff             <= amount_in;
      rem_ff                <= rem_in;
      num_ff                <= num_in;
      quot_ff               <= quot_in;
      step_ff               <= step_in;
      rsp_accepted_ff       <= rsp_accepted_in;
      rsp_cell_count_ff     <= rsp_cell_count_in;
      rsp_accuracy_valid_ff <= rsp_accuracy_valid_in;
      rsp_accuracy_pct_ff   <= rsp_accuracy_pct_in;
   end

   // ports
   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_cell_count     = rsp_cell_count_ff;
   assign rsp_accuracy_valid = rsp_accuracy_valid_ff;
   assign rsp_accuracy_pct   = rsp_accuracy_pct_ff;
   assign pready             = 1'b1;
   assign prdata = (paddr[2] == REG_CLASS_COUNT) ? CSR_W'(class_count_ff) : '0;

   // checks
   `CMA_ASSERT_NOW(a_diag_le_total, clock, reset, 1'b1, diagonal_total_ff <= grand_total_ff, "diagonal total above grand total")
   `CMA_ASSERT_NOW(a_query_fields, clock, reset, rsp_valid && rsp_accuracy_valid, !rsp_accepted && rsp_cell_count == '0, "query result carries cell fields")
   `CMA_ASSERT_NOW(a_pct_range, clock, reset, rsp_valid && rsp_accuracy_valid, int'(rsp_accuracy_pct) <= PCT_SCALE, "accuracy above full scale")
   `CMA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second transfer taken while an item is in flight")

endmodule

// ===== sim/confusion_matrix_accumulator_core_tb.sv =====
// self-checking testbench of the confusion matrix accumulator core
`timescale 1ns / 100ps

module confusion_matrix_accumulator_core_tb;
   import cma_pkg::*;

   localparam int NUM_CLASSES  = MAX_CLASSES_DEFAULT;
   localparam int NUM_CELLS    = NUM_CLASSES * NUM_CLASSES;
   localparam int PHASE_ITEMS  = 130;
   localparam int BURST_ADDS   = 40;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 2_000_000;

   localparam logic [CELL_W-1:0]  CELL_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [PADDR_W-1:0] CLASS_COUNT_ADDR = PADDR_W'(4 * int'(REG_CLASS_COUNT));

   typedef struct packed {
      logic              accepted;
      logic [CELL_W-1:0] cell_count;
      logic              accuracy_valid;
      logic [PCT_W-1:0]  accuracy_pct;
   } cm_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action = ACT_ADD;
   logic [CLASS_W-1:0]  req_expected_class = '0;
   logic [CLASS_W-1:0]  req_actual_class = '0;
   logic [AMOUNT_W-1:0] req_add_amount = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b1;
   logic                rsp_accepted;
   logic [CELL_W-1:0]   rsp_cell_count;
   logic                rsp_accuracy_valid;
   logic [PCT_W-1:0]    rsp_accuracy_pct;

   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [CSR_W-1:0]    pwdata = '0;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // matrix model: cells, running totals and the class setting
   logic [CELL_W-1:0]   cell_model [NUM_CELLS] = '{default: '0};
   logic [TOTAL_W-1:0]  diag_model = '0;
   logic [TOTAL_W-1:0]  total_model = '0;
   logic [CCOUNT_W-1:0] class_count_model = '0;

   cm_result_type       pending_results [$];
   int                  fail_count = 0;
   int unsigned         cycle_count = 0;

   // pacing knobs of both sides
   bit                  pace_on = 1'b1;
   int                  burst_left = 1;
   int                  stall_mode = 1;
   int unsigned         ready_run = 0;

   confusion_matrix_accumulator_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_expected_class (req_expected_class),
      .req_actual_class   (req_actual_class),
      .req_add_amount     (req_add_amount),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_cell_count     (rsp_cell_count),
      .rsp_accuracy_valid (rsp_accuracy_valid),
      .rsp_accuracy_pct   (rsp_accuracy_pct),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("confusion_matrix_accumulator_core_tb NOT OK");
      $finish;
   end

   // result side: run-length stall pattern
   always @(posedge clock) begin
      if (stall_mode == 0) begin
         rsp_ready <= 1'b1;
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else begin
         rsp_ready <= ~rsp_ready;
         ready_run <= rsp_ready ? $urandom_range(0, (stall_mode == 2) ? 9 : 2)
                                : $urandom_range(0, 7);
      end
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin
      cm_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no item outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted, rsp_accepted);
               fail_count++;
            end
            if (rsp_cell_count !== want.cell_count) begin
               $error("cell_count: expected %0d, actual %0d", want.cell_count, rsp_cell_count);
               fail_count++;
            end
            if (rsp_accuracy_valid !== want.accuracy_valid) begin
               $error("accuracy_valid: expected %0d, actual %0d", want.accuracy_valid,
                      rsp_accuracy_valid);
               fail_count++;
            end
            if (rsp_accuracy_pct !== want.accuracy_pct) begin
               $error("accuracy_pct: expected %0d, actual %0d", want.accuracy_pct,
                      rsp_accuracy_pct);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [TOTAL_W-1:0] sat_add_total(logic [TOTAL_W-1:0] acc,
                                                         logic [CELL_W-1:0] grow);
      logic [TOTAL_W:0] sum;
      sum = {1'b0, acc} + (TOTAL_W + 1)'(grow);
      return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
   endfunction

   // apply one item to the matrix model and return the result it yields
   function automatic cm_result_type score_item(action_type act, logic [CLASS_W-1:0] row,
                                                logic [CLASS_W-1:0] col,
                                                logic [AMOUNT_W-1:0] amount);
      cm_result_type       res;
      logic [CCOUNT_W-1:0] lim;
      int unsigned         idx;
      logic [CELL_W-1:0]   count_now;
      logic [CELL_W-1:0]   room;
      logic [CELL_W-1:0]   grow;
      logic [63:0]         pct;
      res = '0;
      lim = (class_count_model < NUM_CLASSES) ? class_count_model : CCOUNT_W'(NUM_CLASSES);
      if ((act == ACT_ADD || act == ACT_READ) && row < lim && col < lim) begin
         idx = row * NUM_CLASSES + col;
         count_now = cell_model[idx];
         if (act == ACT_ADD) begin
            // cell stops at full scale, totals grow by what the cell really grew
            room = CELL_MAX - count_now;
            grow = (CELL_W'(amount) < room) ? CELL_W'(amount) : room;
            count_now = count_now + grow;
            cell_model[idx] = count_now;
            total_model = sat_add_total(total_model, grow);
            if (row == col) diag_model = sat_add_total(diag_model, grow);
         end
         res.accepted = 1'b1;
         res.cell_count = count_now;
      end else if (act == ACT_QUERY && total_model != 0) begin
         pct = (64'(diag_model) * 64'(PCT_SCALE)) / 64'(total_model);
         if (pct > 64'(PCT_SCALE)) pct = 64'(PCT_SCALE);
         res.accuracy_valid = 1'b1;
         res.accuracy_pct = PCT_W'(pct);
      end
      return res;
   endfunction

   // sender bursts: drop valid for a random gap once the burst runs out
   task automatic pace_sender();
      if (!pace_on) return;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
   endtask

   task automatic send_item(input action_type act, input logic [CLASS_W-1:0] row,
                            input logic [CLASS_W-1:0] col, input logic [AMOUNT_W-1:0] amount);
      req_valid          <= 1'b1;
      req_action         <= act;
      req_expected_class <= row;
      req_actual_class   <= col;
      req_add_amount     <= amount;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(score_item(act, row, col, amount));
      pace_sender();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // apb write of class_count once the block is idle, then read it back
   task automatic write_class_count(input logic [CCOUNT_W-1:0] value);
      logic [CSR_W-1:0] readback;
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CLASS_COUNT_ADDR;
      pwdata  <= CSR_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      class_count_model = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== CSR_W'(value)) begin
         $error("class_count: expected %0d, actual %0d", value, readback);
         fail_count++;
      end
   endtask

   function automatic logic [CLASS_W-1:0] pick_class(int unsigned lim);
      if (lim == 0 || $urandom_range(0, 7) == 0) return CLASS_W'($urandom_range(0, 15));
      return CLASS_W'($urandom_range(0, lim - 1));
   endfunction

   task automatic send_random_item();
      int unsigned         pick;
      int unsigned         lim;
      action_type          act;
      logic [CLASS_W-1:0]  row;
      logic [CLASS_W-1:0]  col;
      logic [AMOUNT_W-1:0] amount;
      lim = (class_count_model < NUM_CLASSES) ? class_count_model : NUM_CLASSES;
      pick = $urandom_range(0, 99);
      act = (pick < 68) ? ACT_ADD : (pick < 84) ? ACT_READ : (pick < 95) ? ACT_QUERY : ACT_NONE;
      row = pick_class(lim);
      // lean toward the diagonal so accuracy moves across its range
      col = ($urandom_range(0, 2) == 0) ? row : pick_class(lim);
      case ($urandom_range(0, 9))
         0:       amount = '0;
         1:       amount = '1;
         2, 3, 4: amount = AMOUNT_W'($urandom_range(1, 15));
         default: amount = AMOUNT_W'($urandom);
      endcase
      send_item(act, row, col, amount);
   endtask

   // extremes, every action, refused indices, empty query, unused action
   task automatic test_directed();
      pace_on = 1'b1;
      stall_mode = 1;
      send_item(ACT_READ, 4'd0, 4'd0, 16'd0);
      send_item(ACT_ADD, 4'd0, 4'd0, 16'd5);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
      send_item(ACT_NONE, 4'd0, 4'd0, 16'd0);
      write_class_count(5'd16);
      send_item(ACT_QUERY, 4'd15, 4'd15, 16'hFFFF);
      send_item(ACT_ADD, 4'd15, 4'd15, 16'hFFFF);
      send_item(ACT_ADD, 4'd0, 4'd15, 16'd0);
      send_item(ACT_ADD, 4'd15, 4'd0, 16'd1);
      send_item(ACT_READ, 4'd15, 4'd15, 16'd0);
      send_item(ACT_READ, 4'd0, 4'd15, 16'hFFFF);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
      send_item(ACT_NONE, 4'd15, 4'd15, 16'hFFFF);
      send_item(ACT_ADD, 4'd7, 4'd8, 16'h8000);
      send_item(ACT_QUERY, 4'd5, 4'd10, 16'h5555);
      // narrowed class range refuses indices at the limit
      write_class_count(5'd3);
      send_item(ACT_ADD, 4'd3, 4'd0, 16'd1);
      send_item(ACT_ADD, 4'd0, 4'd3, 16'd1);
      send_item(ACT_ADD, 4'd2, 4'd2, 16'h1234);
      send_item(ACT_READ, 4'd2, 4'd3, 16'd0);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
      // setting above the table size clamps to the table size
      write_class_count(5'd31);
      send_item(ACT_READ, 4'd15, 4'd15, 16'd0);
      send_item(ACT_ADD, 4'd15, 4'd14, 16'd2);
      // shrinking keeps earlier counts in the totals
      write_class_count(5'd1);
      send_item(ACT_ADD, 4'd0, 4'd0, 16'd1);
      send_item(ACT_READ, 4'd1, 4'd0, 16'd0);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
   endtask

   task automatic test_random_phases();
      logic [CCOUNT_W-1:0] setting [8];
      setting = '{5'd16, 5'd2, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16, 5'd0};
      setting[7] = CCOUNT_W'($urandom_range(0, 31));
      for (int i = 0; i < 8; i++) begin
         write_class_count(setting[i]);
         pace_on = (i % 3) != 2;
         stall_mode = i % 3;
         repeat (PHASE_ITEMS) send_random_item();
      end
   endtask

   // back-to-back full-scale adds on one diagonal cell, then a random add, a read, queries and an off-diagonal add
   task automatic test_back_to_back();
      logic [CLASS_W-1:0] row;
      write_class_count(5'd16);
      pace_on = 1'b0;
      stall_mode = 0;
      row = CLASS_W'($urandom_range(0, 15));
      repeat (BURST_ADDS) send_item(ACT_ADD, row, row, 16'hFFFF);
      pace_on = 1'b1;
      stall_mode = 2;
      send_item(ACT_ADD, row, row, AMOUNT_W'($urandom));
      send_item(ACT_READ, row, row, 16'd0);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
      send_item(ACT_ADD, row, row ^ 4'd1, 16'hFFFF);
      send_item(ACT_QUERY, 4'd0, 4'd0, 16'd0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phases();
      test_back_to_back();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("confusion_matrix_accumulator_core_tb OK");
      end else begin
         $display("confusion_matrix_accumulator_core_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/cma_pkg.sv
sv/confusion_matrix_accumulator_core.sv
sim/confusion_matrix_accumulator_core_tb.sv
